/* rtl/array_deque_engine_assert.svh */
// assertion macros for the deque engine
`ifndef ARRAY_DEQUE_ENGINE_ASSERT_SVH
`define ARRAY_DEQUE_ENGINE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ADE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque engine check failed");

// next-cycle implication, checked out of reset
`define ADE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque engine check failed");

`endif

/* rtl/ade_pkg.sv */
// shared types and codes for the deque engine
`timescale 1ns / 1ps
package ade_pkg;

  localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FN_POP_FRONT  = 3'd2;
  localparam logic [2:0] FN_POP_BACK   = 3'd3;
  localparam logic [2:0] FN_LIST      = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic [4:0]         count;
    logic               last;
  } out_t;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_PUSH_FRONT,
    DP_PUSH_BACK,
    DP_POP_FRONT,
    DP_POP_BACK,
    DP_LIST_FIRST,
    DP_LIST_NEXT
  } dp_op_t;

  typedef enum logic [1:0] {
    SRC_VALUE,
    SRC_MEM,
    SRC_ZERO
  } src_t;

  typedef struct packed {
    dp_op_t     op;
    logic       load;
    logic [1:0] status;
    src_t       src;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic list_last;
  } stat_t;

endpackage

/* rtl/ade_ctrl.sv */
// controller: decodes operations and sequences removals and listing
`timescale 1ns / 1ps
module ade_ctrl import ade_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] func,
  output logic       out_valid,
  input  logic       out_stall,
  input  stat_t      stat,
  output cmd_t       cmd
);

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   pop_mode;
  logic   pop_mode_next;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid || !out_stall;
  assign accept   = in_valid && (state == S_IDLE) && out_free;
  assign in_stall = !((state == S_IDLE) && out_free);

  always_comb begin
    cmd           = '{op: DP_NOP, load: 1'b0, status: ST_OK, src: SRC_VALUE, last: 1'b0};
    state_next    = state;
    pop_mode_next = pop_mode;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (func)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
              cmd.load = 1'b1;
              cmd.last = 1'b1;
              cmd.src  = SRC_VALUE;
              if (stat.full) begin
                cmd.status = ST_FULL;
              end else begin
                cmd.status = ST_OK;
                cmd.op     = (func == FN_PUSH_FRONT) ? DP_PUSH_FRONT : DP_PUSH_BACK;
              end
            end
            FN_POP_FRONT, FN_POP_BACK: begin
              if (stat.empty) begin
                cmd.load   = 1'b1;
                cmd.last   = 1'b1;
                cmd.status = ST_EMPTY;
                cmd.src    = SRC_ZERO;
              end else begin
                cmd.op        = (func == FN_POP_FRONT) ? DP_POP_FRONT : DP_POP_BACK;
                pop_mode_next = 1'b1;
                state_next    = S_EMIT;
              end
            end
            FN_LIST: begin
              if (stat.empty) begin
                cmd.load   = 1'b1;
                cmd.last   = 1'b1;
                cmd.status = ST_EMPTY;
                cmd.src    = SRC_ZERO;
              end else begin
                cmd.op        = DP_LIST_FIRST;
                pop_mode_next = 1'b0;
                state_next    = S_EMIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.load   = 1'b1;
          cmd.status = ST_OK;
          cmd.src    = SRC_MEM;
          cmd.last   = pop_mode || stat.list_last;
          if (cmd.last) begin
            state_next = S_IDLE;
          end else begin
            cmd.op = DP_LIST_NEXT;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pop_mode  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      pop_mode <= pop_mode_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/ade_dp.sv */
// datapath: ring buffer store, pointers, count and result register
`timescale 1ns / 1ps
module ade_dp import ade_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] value,
  input  cmd_t               cmd,
  output stat_t              stat,
  output out_t               out_beat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;

  logic [PW-1:0] front;
  logic [PW-1:0] front_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [PW-1:0] idx;
  logic [PW-1:0] idx_next;

  logic [CW-1:0] off;
  logic [CW:0]   sum;
  logic [PW-1:0] ring;
  logic          wr_en;
  logic [PW-1:0] waddr;
  logic          rd_en;
  logic [PW-1:0] raddr;
  logic [CW+4:0] count_ext;

  always_comb begin
    unique case (cmd.op)
      DP_PUSH_BACK: off = count;
      DP_POP_FRONT: off = CW'(1);
      DP_POP_BACK:  off = count - CW'(1);
      DP_LIST_NEXT: off = CW'(idx) + CW'(1);
      default:      off = '0;
    endcase
    sum = (CW+1)'(front) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    ring = sum[PW-1:0];
  end

  always_comb begin
    front_next = front;
    count_next = count;
    idx_next   = idx;
    wr_en      = 1'b0;
    waddr      = ring;
    rd_en      = 1'b0;
    raddr      = ring;
    unique case (cmd.op)
      DP_PUSH_FRONT: begin
        front_next = (front == '0) ? PW'(DEPTH - 1) : front - PW'(1);
        wr_en      = 1'b1;
        waddr      = front_next;
        count_next = count + CW'(1);
      end
      DP_PUSH_BACK: begin
        wr_en      = 1'b1;
        count_next = count + CW'(1);
      end
      DP_POP_FRONT: begin
        rd_en      = 1'b1;
        raddr      = front;
        front_next = ring;
        count_next = count - CW'(1);
      end
      DP_POP_BACK: begin
        rd_en      = 1'b1;
        count_next = count - CW'(1);
      end
      DP_LIST_FIRST: begin
        rd_en    = 1'b1;
        raddr    = front;
        idx_next = '0;
      end
      DP_LIST_NEXT: begin
        rd_en    = 1'b1;
        idx_next = idx + PW'(1);
      end
      default: begin
      end
    endcase
  end

  assign stat.empty     = (count == '0);
  assign stat.full      = (count == CW'(DEPTH));
  assign stat.list_last = (CW'(idx) == count - CW'(1));
  assign count_ext      = (CW+5)'(count_next);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
      idx   <= '0;
    end else begin
      front <= front_next;
      count <= count_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_beat.status <= cmd.status;
      out_beat.count  <= count_ext[4:0];
      out_beat.last   <= cmd.last;
      unique case (cmd.src)
        SRC_VALUE: out_beat.data <= value;
        SRC_MEM:   out_beat.data <= rdata;
        default:   out_beat.data <= '0;
      endcase
    end
  end

endmodule

/* rtl/array_deque_engine.sv */
// top level of the bounded double-ended queue engine
//
//   channel | direction | payload | handshake
//   in      | input     | in_t    | in_valid / in_stall
//   out     | output    | out_t   | out_valid / out_stall
//
// inserts and refused operations load the result register directly; removals go through
// the registered read of the single store read port before their result is loaded
// listing makes one store read per element
// a new beat is taken only once the previous operation has issued its last result
// out_stall holds the result register and the sequencer; no clearing pass after rst
`timescale 1ns / 1ps
`include "array_deque_engine_assert.svh"
module array_deque_engine import ade_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_beat,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_beat
);

  cmd_t  cmd;
  stat_t stat;

  ade_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (in_beat.func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ade_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .value    (in_beat.value),
    .cmd      (cmd),
    .stat     (stat),
    .out_beat (out_beat)
  );

  `ADE_ASSERT_NOW(a_accept_out_free, in_valid && !in_stall, !(out_valid && out_stall))
  `ADE_ASSERT_NOW(a_error_single, out_valid && (out_beat.status != ST_OK), out_beat.last)
  `ADE_ASSERT_NOW(a_empty_count, out_valid && (out_beat.status == ST_EMPTY), out_beat.count == 5'd0)
  `ADE_ASSERT_NEXT(a_load_valid, cmd.load, out_valid)

endmodule
